// ===== hw/rtl/mdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mdq_pkg;

  // Timestamp bits in use (the port carries 48; range 32..48)
  localparam int TIME_BITS = 48;

  localparam int VEL_W   = 16;
  localparam int SPEED_W = 15;
  localparam int COUNT_W = 8;
  localparam int MS_W    = 16;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 16;

  // Register reset values
  localparam logic [SPEED_W-1:0] ENTER_RST   = SPEED_W'(20);
  localparam logic [SPEED_W-1:0] STILL_RST   = SPEED_W'(8);
  localparam logic [COUNT_W-1:0] CONFIRM_RST = COUNT_W'(2);
  localparam logic [MS_W-1:0]    DWELL_RST   = MS_W'(500);
  localparam logic [MS_W-1:0]    HOLD_RST    = MS_W'(300);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    MV_UNKNOWN  = 2'd0,
    MV_APPROACH = 2'd1,
    MV_LEAVE    = 2'd2,
    MV_STILL    = 2'd3
  } mv_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_ENTER   = 3'd0,
    REG_STILL   = 3'd1,
    REG_CONFIRM = 3'd2,
    REG_DWELL   = 3'd3,
    REG_HOLD    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SPEED_W-1:0] enter_speed;
    logic [SPEED_W-1:0] still_speed;
    logic [COUNT_W-1:0] confirm_count;
    logic [MS_W-1:0]    still_dwell_ms;
    logic [MS_W-1:0]    hold_ms;
  } cfg_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VEL_W-1:0] velocity;
    logic [TIME_BITS-1:0]    now_time;
  } item_t;

  typedef struct packed {
    logic gap;
    mv_t  mv;
  } cls_t;

endpackage

`default_nettype wire

// ===== hw/rtl/movement_direction_qualifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Signals                         | Contents
// ----------+-----+---------------------------------+----------------------------------
// s_        | in  | s_tvalid s_tready s_tdata s_tuser | velocity samples and clears
// m_        | out | m_tvalid m_tready m_tdata       | qualified movement state
// cfg_      | in  | cfg_we cfg_addr cfg_data        | threshold and timing registers
//
// One word per cycle sustained while the result side does not stall; each result is registered.
// The work per word sits between the input register and the result register.
// Reset restores register defaults and returns the state to unknown.
// When the result register is full and not taken, the input register holds and
// s_tready drops only once both registers are occupied.
module movement_direction_qualifier (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [63:0]                s_tdata,   // [15:0] velocity, [63:16] now_time
  input  wire logic                       s_tuser,   // [0] opcode
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [7:0]                      m_tdata,   // [1:0] movement, [7:2] zero
  input  wire logic                       cfg_we,
  input  wire logic [mdq_pkg::ADDR_W-1:0] cfg_addr,
  input  wire logic [mdq_pkg::DATA_W-1:0] cfg_data
);

  mdq_pkg::cfg_t  cfg;
  mdq_pkg::item_t in_item;
  logic           in_valid;
  logic           advance;
  logic           fire;
  mdq_pkg::mv_t   result_mv;
  mdq_pkg::mv_t   out_mv;

  mdq_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register: load on accept, hold while the result side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op       <= mdq_pkg::op_t'(s_tuser);
      in_item.velocity <= $signed(s_tdata[15:0]);
      in_item.now_time <= s_tdata[16 +: mdq_pkg::TIME_BITS];
    end
  end

  mdq_track u_track (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (in_item),
    .cfg      (cfg),
    .movement (result_mv)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_mv <= result_mv;
    end
  end

  assign m_tdata = {6'b000000, out_mv};

endmodule

`default_nettype wire

// ===== hw/rtl/mdq_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mdq_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [mdq_pkg::ADDR_W-1:0] cfg_addr,
  input  wire logic [mdq_pkg::DATA_W-1:0] cfg_data,
  output mdq_pkg::cfg_t                   cfg
);

  // Write one register per cycle; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enter_speed    <= mdq_pkg::ENTER_RST;
      cfg.still_speed    <= mdq_pkg::STILL_RST;
      cfg.confirm_count  <= mdq_pkg::CONFIRM_RST;
      cfg.still_dwell_ms <= mdq_pkg::DWELL_RST;
      cfg.hold_ms        <= mdq_pkg::HOLD_RST;
    end else if (cfg_we) begin
      case (mdq_pkg::reg_idx_t'(cfg_addr))
        mdq_pkg::REG_ENTER:   cfg.enter_speed    <= cfg_data[mdq_pkg::SPEED_W-1:0];
        mdq_pkg::REG_STILL:   cfg.still_speed    <= cfg_data[mdq_pkg::SPEED_W-1:0];
        mdq_pkg::REG_CONFIRM: cfg.confirm_count  <= cfg_data[mdq_pkg::COUNT_W-1:0];
        mdq_pkg::REG_DWELL:   cfg.still_dwell_ms <= cfg_data[mdq_pkg::MS_W-1:0];
        mdq_pkg::REG_HOLD:    cfg.hold_ms        <= cfg_data[mdq_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mdq_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mdq_classify (
  input  wire logic signed [mdq_pkg::VEL_W-1:0]   velocity,
  input  wire logic        [mdq_pkg::SPEED_W-1:0] enter_speed,
  input  wire logic        [mdq_pkg::SPEED_W-1:0] still_speed,
  output mdq_pkg::cls_t                           cls
);

  logic signed [mdq_pkg::VEL_W:0] vel_x;
  logic signed [mdq_pkg::VEL_W:0] enter_x;
  logic signed [mdq_pkg::VEL_W:0] still_x;

  // Widen by one bit so the negated thresholds never overflow
  assign vel_x   = {velocity[mdq_pkg::VEL_W-1], velocity};
  assign enter_x = $signed({2'b00, enter_speed});
  assign still_x = $signed({2'b00, still_speed});

  // Moving zones win over the stationary band when they overlap
  always_comb begin
    cls.gap = 1'b0;
    cls.mv  = mdq_pkg::MV_UNKNOWN;
    if (vel_x >= enter_x) begin
      cls.mv = mdq_pkg::MV_APPROACH;
    end else if (vel_x <= -enter_x) begin
      cls.mv = mdq_pkg::MV_LEAVE;
    end else if (vel_x >= -still_x && vel_x <= still_x) begin
      cls.mv = mdq_pkg::MV_STILL;
    end else begin
      cls.gap = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mdq_track.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mdq_track (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire mdq_pkg::item_t item,
  input  wire mdq_pkg::cfg_t  cfg,
  output mdq_pkg::mv_t       movement
);

  localparam int TB = mdq_pkg::TIME_BITS;

  mdq_pkg::mv_t                  cur_state;
  mdq_pkg::mv_t                  cur_state_next;
  mdq_pkg::mv_t                  cand_state;
  mdq_pkg::mv_t                  cand_state_next;
  logic [mdq_pkg::COUNT_W-1:0]   cand_count;
  logic [mdq_pkg::COUNT_W-1:0]   cand_count_next;
  logic [TB-1:0]                 cand_start;
  logic [TB-1:0]                 cand_start_next;
  logic [TB:0]                   hold_until;
  logic [TB:0]                   hold_until_next;

  mdq_pkg::cls_t                 cls;
  logic                          drop;
  logic                          is_new;
  logic [mdq_pkg::COUNT_W-1:0]   count_eff;
  logic [TB-1:0]                 start_eff;
  logic [TB:0]                   elapsed;
  logic [TB-1:0]                 dwell;
  logic                          confirm_ok;

  mdq_classify u_classify (
    .velocity    (item.velocity),
    .enter_speed (cfg.enter_speed),
    .still_speed (cfg.still_speed),
    .cls         (cls)
  );

  // Candidate bookkeeping for this word
  assign drop      = cls.gap || (cls.mv == cur_state);
  assign is_new    = (cls.mv != cand_state);
  assign count_eff = is_new ? mdq_pkg::COUNT_W'(1) :
                     (cand_count == mdq_pkg::COUNT_MAX) ? cand_count :
                     cand_count + mdq_pkg::COUNT_W'(1);
  assign start_eff = is_new ? item.now_time : cand_start;
  assign elapsed   = {1'b0, item.now_time} - {1'b0, start_eff};
  assign dwell     = (cls.mv == mdq_pkg::MV_STILL) ?
                     {{(TB-mdq_pkg::MS_W){1'b0}}, cfg.still_dwell_ms} : '0;

  // Count, hold and dwell tests; a borrow means time went backwards
  assign confirm_ok = (count_eff >= cfg.confirm_count) &&
                      ({1'b0, item.now_time} >= hold_until) &&
                      !elapsed[TB] && (elapsed[TB-1:0] >= dwell);

  always_comb begin
    cur_state_next  = cur_state;
    cand_state_next = cand_state;
    cand_count_next = cand_count;
    cand_start_next = cand_start;
    hold_until_next = hold_until;
    if (fire) begin
      if (item.op == mdq_pkg::OP_CLEAR) begin
        cur_state_next  = mdq_pkg::MV_UNKNOWN;
        cand_state_next = mdq_pkg::MV_UNKNOWN;
        cand_count_next = '0;
        cand_start_next = '0;
        hold_until_next = '0;
      end else if (drop) begin
        cand_state_next = cur_state;
        cand_count_next = '0;
        cand_start_next = item.now_time;
      end else begin
        cand_state_next = cls.mv;
        cand_count_next = count_eff;
        cand_start_next = start_eff;
        if (confirm_ok) begin
          cur_state_next  = cls.mv;
          cand_count_next = '0;
          hold_until_next = {1'b0, item.now_time} +
                            {{(TB+1-mdq_pkg::MS_W){1'b0}}, cfg.hold_ms};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state  <= mdq_pkg::MV_UNKNOWN;
      cand_state <= mdq_pkg::MV_UNKNOWN;
      cand_count <= '0;
      cand_start <= '0;
      hold_until <= '0;
    end else begin
      cur_state  <= cur_state_next;
      cand_state <= cand_state_next;
      cand_count <= cand_count_next;
      cand_start <= cand_start_next;
      hold_until <= hold_until_next;
    end
  end

  // Result is the state after this word
  assign movement = cur_state_next;

  // A live candidate always differs from the current state
  a_cand_count: assert property (@(posedge clk) disable iff (rst)
    (cand_count == '0) == (cand_state == cur_state))
    else $error("candidate count out of step with candidate state");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == mdq_pkg::OP_CLEAR |=>
      cur_state == mdq_pkg::MV_UNKNOWN && hold_until == '0)
    else $error("clear did not return state to unknown");

  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(cur_state) && $stable(cand_count) && $stable(hold_until))
    else $error("state moved without a word");

  a_hold_set: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == mdq_pkg::OP_UPDATE && cur_state_next != cur_state |=>
      hold_until >= {1'b0, $past(item.now_time)})
    else $error("hold time not armed on state change");

endmodule

`default_nettype wire
